FILE: rtl/core/sorted_list_insert_buffer_unit_macros.svh
`ifndef SORTED_LIST_INSERT_BUFFER_UNIT_MACROS_SVH
`define SORTED_LIST_INSERT_BUFFER_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define SLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked on every clock edge outside reset
`define SLI_ASSERT_IMP(label, pre, post, msg) \
  `SLI_ASSERT(label, (pre) |-> (post), msg)

`endif

FILE: rtl/core/sli_pkg.sv
`timescale 1ns / 1ps

package sli_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_READ   = 2'd2
  } sli_action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } sli_status_e;

  localparam int unsigned ValW = 32;
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  typedef struct packed {
    logic write;
    logic ins;
    logic rotate;
  } sli_cmd_t;

endpackage

FILE: rtl/core/sorted_list_insert_buffer_unit.sv
`timescale 1ns / 1ps
// channel | valid      | ready       | payload
// in      | in_valid_i | in_ready_o  | action_i, item_value_i
// out     | out_valid_o| out_ready_i | out_value_o, status_o, entry_count_o, last_o
//
// append or insert: every cell compares and shifts at once, and the next beat is taken when the result slot frees
// each result beat is registered and shows in the cycle after its input beat
// read out: one beat per cycle while out_ready_i stays high, the list rotates through cell 0 and ends as it began
// a read out of n entries holds the input off after acceptance until its last beat is loaded
// a result held by out_ready_i low holds the input off and pauses a read out
// reset empties the list
module sorted_list_insert_buffer_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic signed [sli_pkg::ValW-1:0]     item_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sli_pkg::ValW-1:0]     out_value_o,
  output logic [1:0]                          status_o,
  output logic [$clog2(DEPTH+1)-1:0]          entry_count_o,
  output logic                                last_o
);
  import sli_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } sli_state_e;

  sli_state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] rd_left_q, rd_left_d;
  logic          out_valid_q, out_valid_d;
  logic signed [ValW-1:0] out_value_q, out_value_d;
  sli_status_e   status_q, status_d;
  logic [CW-1:0] count_q, count_d;
  logic          last_q, last_d;
  logic          load;

  sli_cmd_t cmd;
  logic signed [ValW-1:0] val [DEPTH];
  logic                   occ [DEPTH];
  logic                   found [DEPTH+1];

  logic slot_free, in_fire, full;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (fill_q == CW'(DEPTH));

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValW-1:0] prev_val, next_val;
    logic                   prev_occ, next_occ;
    if (i == 0) begin : g_head
      assign prev_val = ValMin;
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_val = val[i-1];
      assign prev_occ = occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_val = '0;
      assign next_occ = 1'b0;
    end else begin : g_body
      assign next_val = val[i+1];
      assign next_occ = occ[i+1];
    end
    sli_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .new_val_i  (item_value_i),
      .prev_val_i (prev_val),
      .prev_occ_i (prev_occ),
      .next_val_i (next_val),
      .next_occ_i (next_occ),
      .head_val_i (val[0]),
      .found_i    (found[i]),
      .found_o    (found[i+1]),
      .val_o      (val[i]),
      .occ_o      (occ[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_left_d   = rd_left_q;
    cmd         = '0;
    load        = 1'b0;
    out_value_d = out_value_q;
    status_d    = status_q;
    count_d     = count_q;
    last_d      = last_q;
    if (in_fire) begin
      case (sli_action_e'(action_i))
        ACT_APPEND, ACT_INSERT: begin
          load        = 1'b1;
          out_value_d = item_value_i;
          last_d      = 1'b1;
          if (full) begin
            status_d = STAT_FULL;
            count_d  = fill_q;
          end else begin
            cmd.write = 1'b1;
            cmd.ins   = (sli_action_e'(action_i) == ACT_INSERT);
            fill_d    = fill_q + CW'(1);
            status_d  = STAT_OK;
            count_d   = fill_q + CW'(1);
          end
        end
        ACT_READ: begin
          load    = 1'b1;
          count_d = fill_q;
          if (fill_q == '0) begin
            out_value_d = '0;
            status_d    = STAT_EMPTY;
            last_d      = 1'b1;
          end else begin
            out_value_d = val[0];
            status_d    = STAT_OK;
            last_d      = (fill_q == CW'(1));
            cmd.rotate  = 1'b1;
            rd_left_d   = fill_q - CW'(1);
            if (fill_q != CW'(1)) begin
              state_d = ST_READ;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == ST_READ && slot_free) begin
      load        = 1'b1;
      out_value_d = val[0];
      status_d    = STAT_OK;
      count_d     = fill_q;
      last_d      = (rd_left_q == CW'(1));
      cmd.rotate  = 1'b1;
      rd_left_d   = rd_left_q - CW'(1);
      if (rd_left_q == CW'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    status_q    <= status_d;
    count_q     <= count_d;
    last_q      <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign last_o        = last_q;

endmodule

FILE: rtl/core/sli_cell.sv
`timescale 1ns / 1ps

module sli_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sli_pkg::sli_cmd_t              cmd_i,
  input  logic signed [sli_pkg::ValW-1:0] new_val_i,
  input  logic signed [sli_pkg::ValW-1:0] prev_val_i,
  input  logic                           prev_occ_i,
  input  logic signed [sli_pkg::ValW-1:0] next_val_i,
  input  logic                           next_occ_i,
  input  logic signed [sli_pkg::ValW-1:0] head_val_i,
  input  logic                           found_i,
  output logic                           found_o,
  output logic signed [sli_pkg::ValW-1:0] val_o,
  output logic                           occ_o
);
  import sli_pkg::*;

  logic signed [ValW-1:0] val_q, val_d;
  logic                   occ_q, occ_d;
  logic                   cand, first_free, take_new;

  // sorted slot: this entry at least the value, previous at most the value
  assign cand       = cmd_i.ins && occ_q && (val_q >= new_val_i) && (prev_val_i <= new_val_i);
  assign first_free = !occ_q && prev_occ_i;
  assign take_new   = !found_i && (cand || first_free);
  assign found_o    = found_i || cand || first_free;

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (cmd_i.write) begin
      if (found_i) begin
        val_d = prev_val_i;
        occ_d = prev_occ_i;
      end else if (take_new) begin
        val_d = new_val_i;
        occ_d = 1'b1;
      end
    end else if (cmd_i.rotate && occ_q) begin
      val_d = next_occ_i ? next_val_i : head_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;

endmodule

FILE: rtl/core/sli_checker.sv
`timescale 1ns / 1ps
`include "sorted_list_insert_buffer_unit_macros.svh"

module sli_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [1:0]                      status_o,
  input logic [$clog2(DEPTH+1)-1:0]      entry_count_o,
  input logic                            last_o
);
  import sli_pkg::*;

  `SLI_ASSERT_IMP(a_out_hold, out_valid_o && !out_ready_i, ##1 out_valid_o, "out beat dropped while stalled")
  `SLI_ASSERT_IMP(a_empty_beat, out_valid_o && status_o == STAT_EMPTY, entry_count_o == '0 && last_o, "empty status with entries or without last")
  `SLI_ASSERT_IMP(a_full_beat, out_valid_o && status_o == STAT_FULL, entry_count_o == ($clog2(DEPTH+1))'(DEPTH) && last_o, "full status on a list that is not full")
  `SLI_ASSERT_IMP(a_mid_beat, out_valid_o && !last_o, status_o == STAT_OK && entry_count_o != '0, "read out beat without last is not ok")

endmodule

bind sorted_list_insert_buffer_unit sli_checker #(.DEPTH(DEPTH)) u_sli_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .entry_count_o (entry_count_o),
  .last_o        (last_o)
);
